FILE: rtl/icp_pkg.sv
`default_nettype none

package icp_pkg;

  localparam int MEM_WORDS = 4096;
  localparam int ADDR_W    = $clog2(MEM_WORDS);
  localparam int WORD_W    = 64;
  localparam int RUN_LIMIT = 100000;
  localparam int RUN_W     = $clog2(RUN_LIMIT + 1);

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_RESTART = 2'd1;
  localparam logic [1:0] OP_SUPPLY  = 2'd2;
  localparam logic [1:0] OP_RUN     = 2'd3;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_OUTPUT   = 3'd1;
  localparam logic [2:0] ST_AWAIT    = 3'd2;
  localparam logic [2:0] ST_HALTED   = 3'd3;
  localparam logic [2:0] ST_BAD_OPC  = 3'd4;
  localparam logic [2:0] ST_BAD_ADDR = 3'd5;

  typedef struct packed {
    logic [3:0] d4;
    logic [3:0] d3;
    logic [3:0] d2;
    logic [3:0] d1;
    logic [3:0] d0;
  } icp_dig_t;

endpackage

`default_nettype wire

FILE: rtl/icp_ram.sv
`default_nettype none

module icp_ram #(
  parameter int DEPTH  = 4096,
  parameter int WIDTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/icp_digits.sv
`default_nettype none

module icp_digits (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [62:0]            word,
  output logic                        done,
  output icp_pkg::icp_dig_t           digits
);

  import icp_pkg::*;

  localparam int DIG_STEPS = 21;

  // One doubling of the five-digit decimal value, the top carry dropped,
  // so the register keeps the word modulo 100000.
  function automatic logic [19:0] dabble(input logic [19:0] v, input logic b);
    logic [19:0] a;
    a = v;
    for (int i = 0; i < 5; i++) begin
      if (a[i*4 +: 4] >= 4'd5) begin
        a[i*4 +: 4] = a[i*4 +: 4] + 4'd3;
      end
    end
    return {a[18:0], b};
  endfunction

  logic [62:0] sh_r;
  logic [19:0] bcd_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == 5'(DIG_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= word;
      bcd_r <= '0;
    end else if (busy_r) begin
      sh_r  <= {sh_r[59:0], 3'd0};
      bcd_r <= dabble(dabble(dabble(bcd_r, sh_r[62]), sh_r[61]), sh_r[60]);
    end
  end

  assign done   = done_r;
  assign digits = bcd_r;

endmodule

`default_nettype wire

FILE: rtl/icp_mul.sv
`default_nettype none

module icp_mul (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic      [63:0] product
);

  import icp_pkg::*;

  logic [1:0]  step_r;
  logic        busy_r;
  logic [63:0] pp_r;
  logic [63:0] acc_r;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] mp;

  always_comb begin
    case (step_r)
      2'd0: begin
        ma = a[31:0];
        mb = b[31:0];
      end
      2'd1: begin
        ma = a[31:0];
        mb = b[63:32];
      end
      default: begin
        ma = a[63:32];
        mb = b[31:0];
      end
    endcase
    mp = ma * mb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 2'd1;
      if (step_r == 2'd3) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      pp_r <= (step_r == 2'd0) ? mp : {mp[31:0], 32'd0};
      if (step_r == 2'd1) begin
        acc_r <= pp_r;
      end else begin
        acc_r <= acc_r + pp_r;
      end
    end
  end

  assign done    = busy_r && (step_r == 2'd3);
  assign product = acc_r + pp_r;

endmodule

`default_nettype wire

FILE: rtl/intcode_processor_unit.sv
// Intcode processor. Items arrive on the in_ stream: in_tuser selects load word,
// restart, supply input and run, or run. Each transfer gives exactly one result on
// the out_ stream, with the status in out_tuser and the output value in out_tdata.
// A load or restart passes from the command state to the result state. A run executes
// instructions one at a time against the single word memory: a fetch, a decimal
// decode of the instruction word, a read of each parameter and, in position or
// relative mode, of its value, and the execute step (a multiply uses the multiplier),
// until an output, an input wait, a halt, a fault or 100000 instructions.
// After reset the block clears its 4096-word memory, one word a cycle, and takes
// no item meanwhile. The pc, relative base, input slot and halted flag reset to zero.
// Only one item is worked on at a time. A finished result sits in the output
// register while the next item is accepted; if the receiver stalls, a second
// result waits in the block until the register is free, and no item is taken.
`default_nettype none

module intcode_processor_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // load_address [11:0], load_word [75:12], input_value [139:76]
  input  wire logic [143:0] in_tdata,
  // operation [1:0]
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // output_value [63:0]
  output logic      [63:0]  out_tdata,
  // status [2:0]
  output logic      [2:0]   out_tuser
);

  import icp_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CMD    = 4'd2;
  localparam logic [3:0] S_FETCH  = 4'd3;
  localparam logic [3:0] S_FWAIT  = 4'd4;
  localparam logic [3:0] S_DEC    = 4'd5;
  localparam logic [3:0] S_OPC    = 4'd6;
  localparam logic [3:0] S_PARAM  = 4'd7;
  localparam logic [3:0] S_PWAIT  = 4'd8;
  localparam logic [3:0] S_VWAIT  = 4'd9;
  localparam logic [3:0] S_EXEC   = 4'd10;
  localparam logic [3:0] S_MUL    = 4'd11;
  localparam logic [3:0] S_RESULT = 4'd12;

  localparam logic [6:0] OPC_ADD  = 7'd1;
  localparam logic [6:0] OPC_MUL  = 7'd2;
  localparam logic [6:0] OPC_IN   = 7'd3;
  localparam logic [6:0] OPC_OUT  = 7'd4;
  localparam logic [6:0] OPC_JT   = 7'd5;
  localparam logic [6:0] OPC_JF   = 7'd6;
  localparam logic [6:0] OPC_LT   = 7'd7;
  localparam logic [6:0] OPC_EQ   = 7'd8;
  localparam logic [6:0] OPC_ARB  = 7'd9;
  localparam logic [6:0] OPC_HALT = 7'd99;

  localparam logic [3:0] MODE_POS = 4'd0;
  localparam logic [3:0] MODE_REL = 4'd2;

  localparam logic [1:0] WR_NONE = 2'd3;
  localparam logic [63:0] MEM_LIM = 64'(MEM_WORDS);

  logic [3:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [63:0]       pc_r, pc_nxt;
  logic [63:0]       rb_r, rb_nxt;
  logic [63:0]       slot_r, slot_nxt;
  logic              slot_full_r, slot_full_nxt;
  logic              halted_r, halted_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [11:0]       ld_addr_r, ld_addr_nxt;
  logic [63:0]       ld_word_r, ld_word_nxt;
  logic [63:0]       in_val_r, in_val_nxt;
  logic [6:0]        opc_r, opc_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [1:0]        wr_r, wr_nxt;
  logic [1:0]        k_r, k_nxt;
  logic [63:0]       addr_r [3];
  logic [63:0]       addr_nxt [3];
  logic [63:0]       val_r [3];
  logic [63:0]       val_nxt [3];
  logic [RUN_W-1:0]  n_r, n_nxt;
  logic [2:0]        res_st_r, res_st_nxt;
  logic [63:0]       res_val_r, res_val_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_st_r, out_st_nxt;
  logic [63:0]       out_val_r, out_val_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [63:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [63:0]       ram_rdata;

  logic              dig_start;
  logic              dig_done;
  icp_dig_t          dig;
  logic              mul_start;
  logic              mul_done;
  logic [63:0]       mul_prod;

  logic [6:0]        dec_opc;
  logic [3:0]        cur_mode;
  logic [63:0]       param_at;
  logic [63:0]       eff_addr;
  logic [RUN_W-1:0]  n_inc;
  logic              step_done;
  logic              accept;

  icp_ram #(
    .DEPTH (MEM_WORDS),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  icp_digits u_digits (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (dig_start),
    .word   (ram_rdata[62:0]),
    .done   (dig_done),
    .digits (dig)
  );

  icp_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (val_r[0]),
    .b       (val_r[1]),
    .done    (mul_done),
    .product (mul_prod)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = out_val_r;

  assign dec_opc  = 7'({dig.d1, 3'd0}) + 7'({dig.d1, 1'b0}) + 7'(dig.d0);
  assign param_at = pc_r + 64'd1 + 64'(k_r);
  assign n_inc    = n_r + RUN_W'(1);

  always_comb begin
    case (k_r)
      2'd0:    cur_mode = dig.d2;
      2'd1:    cur_mode = dig.d3;
      default: cur_mode = dig.d4;
    endcase
    eff_addr = (cur_mode == MODE_REL) ? ram_rdata + rb_r : ram_rdata;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    pc_nxt        = pc_r;
    rb_nxt        = rb_r;
    slot_nxt      = slot_r;
    slot_full_nxt = slot_full_r;
    halted_nxt    = halted_r;
    op_nxt        = op_r;
    ld_addr_nxt   = ld_addr_r;
    ld_word_nxt   = ld_word_r;
    in_val_nxt    = in_val_r;
    opc_nxt       = opc_r;
    cnt_nxt       = cnt_r;
    wr_nxt        = wr_r;
    k_nxt         = k_r;
    addr_nxt      = addr_r;
    val_nxt       = val_r;
    n_nxt         = n_r;
    res_st_nxt    = res_st_r;
    res_val_nxt   = res_val_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_st_nxt    = out_st_r;
    out_val_nxt   = out_val_r;
    ram_we        = 1'b0;
    ram_waddr     = clr_r;
    ram_wdata     = '0;
    ram_raddr     = pc_r[ADDR_W-1:0];
    dig_start     = 1'b0;
    mul_start     = 1'b0;
    step_done     = 1'b0;

    case (state_r)
      S_CLEAR: begin
        ram_we  = 1'b1;
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt      = in_tuser;
          ld_addr_nxt = in_tdata[11:0];
          ld_word_nxt = in_tdata[75:12];
          in_val_nxt  = in_tdata[139:76];
          state_nxt   = S_CMD;
        end
      end
      S_CMD: begin
        res_val_nxt = '0;
        res_st_nxt  = ST_DONE;
        state_nxt   = S_RESULT;
        case (op_r)
          OP_LOAD: begin
            if (64'(ld_addr_r) < MEM_LIM) begin
              ram_we    = 1'b1;
              ram_waddr = ld_addr_r[ADDR_W-1:0];
              ram_wdata = ld_word_r;
            end else begin
              res_st_nxt = ST_BAD_ADDR;
            end
          end
          OP_RESTART: begin
            pc_nxt        = '0;
            rb_nxt        = '0;
            halted_nxt    = 1'b0;
            slot_nxt      = '0;
            slot_full_nxt = 1'b0;
          end
          default: begin
            if (op_r == OP_SUPPLY) begin
              slot_nxt      = in_val_r;
              slot_full_nxt = 1'b1;
            end
            n_nxt = '0;
            if (halted_r) begin
              res_st_nxt = ST_HALTED;
            end else begin
              state_nxt = S_FETCH;
            end
          end
        endcase
      end
      S_FETCH: begin
        if (pc_r >= MEM_LIM) begin
          res_st_nxt = ST_BAD_ADDR;
          state_nxt  = S_RESULT;
        end else begin
          state_nxt = S_FWAIT;
        end
      end
      S_FWAIT: begin
        if (ram_rdata[63]) begin
          res_st_nxt = ST_BAD_OPC;
          state_nxt  = S_RESULT;
        end else begin
          dig_start = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (dig_done) begin
          state_nxt = S_OPC;
        end
      end
      S_OPC: begin
        opc_nxt   = dec_opc;
        k_nxt     = '0;
        state_nxt = S_PARAM;
        case (dec_opc)
          OPC_ADD, OPC_MUL, OPC_LT, OPC_EQ: begin
            cnt_nxt = 2'd3;
            wr_nxt  = 2'd2;
          end
          OPC_JT, OPC_JF: begin
            cnt_nxt = 2'd2;
            wr_nxt  = WR_NONE;
          end
          OPC_IN: begin
            cnt_nxt = 2'd1;
            wr_nxt  = 2'd0;
          end
          OPC_OUT, OPC_ARB: begin
            cnt_nxt = 2'd1;
            wr_nxt  = WR_NONE;
          end
          OPC_HALT: begin
            halted_nxt = 1'b1;
            res_st_nxt = ST_HALTED;
            state_nxt  = S_RESULT;
          end
          default: begin
            res_st_nxt = ST_BAD_OPC;
            state_nxt  = S_RESULT;
          end
        endcase
      end
      S_PARAM: begin
        ram_raddr = param_at[ADDR_W-1:0];
        if (param_at >= MEM_LIM) begin
          res_st_nxt = ST_BAD_ADDR;
          state_nxt  = S_RESULT;
        end else begin
          state_nxt = S_PWAIT;
        end
      end
      S_PWAIT: begin
        addr_nxt[k_r] = eff_addr;
        ram_raddr     = eff_addr[ADDR_W-1:0];
        if (cur_mode == MODE_POS || cur_mode == MODE_REL) begin
          if (eff_addr >= MEM_LIM) begin
            res_st_nxt = ST_BAD_ADDR;
            state_nxt  = S_RESULT;
          end else begin
            state_nxt = S_VWAIT;
          end
        end else begin
          val_nxt[k_r] = ram_rdata;
          if (k_r == wr_r && eff_addr >= MEM_LIM) begin
            res_st_nxt = ST_BAD_ADDR;
            state_nxt  = S_RESULT;
          end else if (k_r + 2'd1 == cnt_r) begin
            state_nxt = S_EXEC;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = S_PARAM;
          end
        end
      end
      S_VWAIT: begin
        val_nxt[k_r] = ram_rdata;
        if (k_r + 2'd1 == cnt_r) begin
          state_nxt = S_EXEC;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_PARAM;
        end
      end
      S_EXEC: begin
        ram_waddr = addr_r[2][ADDR_W-1:0];
        case (opc_r)
          OPC_ADD: begin
            ram_we    = 1'b1;
            ram_wdata = val_r[0] + val_r[1];
            pc_nxt    = pc_r + 64'd4;
            step_done = 1'b1;
          end
          OPC_MUL: begin
            mul_start = 1'b1;
            state_nxt = S_MUL;
          end
          OPC_IN: begin
            if (!slot_full_r) begin
              res_st_nxt = ST_AWAIT;
              state_nxt  = S_RESULT;
            end else begin
              ram_we        = 1'b1;
              ram_waddr     = addr_r[0][ADDR_W-1:0];
              ram_wdata     = slot_r;
              slot_full_nxt = 1'b0;
              pc_nxt        = pc_r + 64'd2;
              step_done     = 1'b1;
            end
          end
          OPC_OUT: begin
            pc_nxt      = pc_r + 64'd2;
            res_st_nxt  = ST_OUTPUT;
            res_val_nxt = val_r[0];
            state_nxt   = S_RESULT;
          end
          OPC_JT: begin
            pc_nxt    = (val_r[0] != '0) ? val_r[1] : pc_r + 64'd3;
            step_done = 1'b1;
          end
          OPC_JF: begin
            pc_nxt    = (val_r[0] == '0) ? val_r[1] : pc_r + 64'd3;
            step_done = 1'b1;
          end
          OPC_LT: begin
            ram_we    = 1'b1;
            ram_wdata = 64'($signed(val_r[0]) < $signed(val_r[1]));
            pc_nxt    = pc_r + 64'd4;
            step_done = 1'b1;
          end
          OPC_EQ: begin
            ram_we    = 1'b1;
            ram_wdata = 64'(val_r[0] == val_r[1]);
            pc_nxt    = pc_r + 64'd4;
            step_done = 1'b1;
          end
          default: begin
            rb_nxt    = rb_r + val_r[0];
            pc_nxt    = pc_r + 64'd2;
            step_done = 1'b1;
          end
        endcase
      end
      S_MUL: begin
        ram_waddr = addr_r[2][ADDR_W-1:0];
        ram_wdata = mul_prod;
        if (mul_done) begin
          ram_we    = 1'b1;
          pc_nxt    = pc_r + 64'd4;
          step_done = 1'b1;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_val_nxt   = res_val_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (step_done) begin
      n_nxt = n_inc;
      if (n_inc == RUN_W'(RUN_LIMIT)) begin
        res_st_nxt = ST_DONE;
        state_nxt  = S_RESULT;
      end else begin
        state_nxt = S_FETCH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      pc_r        <= '0;
      rb_r        <= '0;
      slot_r      <= '0;
      slot_full_r <= 1'b0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pc_r        <= pc_nxt;
      rb_r        <= rb_nxt;
      slot_r      <= slot_nxt;
      slot_full_r <= slot_full_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    ld_addr_r <= ld_addr_nxt;
    ld_word_r <= ld_word_nxt;
    in_val_r  <= in_val_nxt;
    opc_r     <= opc_nxt;
    cnt_r     <= cnt_nxt;
    wr_r      <= wr_nxt;
    k_r       <= k_nxt;
    addr_r    <= addr_nxt;
    val_r     <= val_nxt;
    n_r       <= n_nxt;
    res_st_r  <= res_st_nxt;
    res_val_r <= res_val_nxt;
    out_st_r  <= out_st_nxt;
    out_val_r <= out_val_nxt;
  end

endmodule

`default_nettype wire
